/* rtl/dnps_pkg.sv */
// ----------------------------------------------------------------------------
// Directional nearest-point search: shared package
// Controller states, direction codes, action codes and pipeline constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dnps_pkg;

  typedef logic [2:0] dir_t;

  localparam dir_t DIR_ANY   = 3'd0;
  localparam dir_t DIR_UP    = 3'd1;
  localparam dir_t DIR_DOWN  = 3'd2;
  localparam dir_t DIR_LEFT  = 3'd3;
  localparam dir_t DIR_RIGHT = 3'd4;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Cycles from the last table read to the last update of the running best.
  localparam int SCAN_LATENCY = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CUR_RD,
    ST_CUR_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/directional_nearest_point_search_core.sv */
// ----------------------------------------------------------------------------
// Directional nearest-point search core
// Point table in a RAM, scanned one entry per cycle for the nearest point.
// ----------------------------------------------------------------------------
// The block holds a table of 2-D points in one RAM. A command with action
// write stores a saturated point and answers found=0 in the cycle after the
// store; a command with action search reads the current point, then streams
// entries 0 .. count-1 through a three-stage distance pipeline into a
// running best. busy is high from the accept edge until the cycle that shows
// the result; the result is on found and nearest_index for the single cycle
// that done is high, and the receiver cannot stall it. A search steps
// through current read, current wait, scan and drain; its length is set by
// the single RAM read port, which sees one entry per cycle. A search whose
// current index is not below the effective count answers found=0 from the
// current read without scanning. The table is not cleared at reset, so
// there is no clearing pass; searching over unwritten entries is undefined.
// entry_count is written through the cfg beat at any time, and is meant to
// be changed only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_nearest_point_search_core #(
  parameter int MAX_ENTRIES = 128,
  parameter int COORD_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  // Command channel
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [6:0]          entry_index,
  input  logic signed [15:0]  coord_x,
  input  logic signed [15:0]  coord_y,
  input  dnps_pkg::dir_t      direction,
  input  logic [6:0]          current_index,
  // Result strobe
  output logic                done,
  output logic                found,
  output logic [6:0]          nearest_index,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  import dnps_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int DIST_W = 2 * (COORD_BITS + 2) + 1;
  localparam int DRN_W  = $clog2(SCAN_LATENCY);
  localparam int EXT_W  = 26;

  localparam logic signed [EXT_W-1:0] CMAX = EXT_W'(2 ** (COORD_BITS - 1) - 1);
  localparam logic signed [EXT_W-1:0] CMIN = -CMAX - EXT_W'(1);

  state_t state, state_next;

  logic [7:0]                   entry_count;
  logic [CNT_W-1:0]             eff_count;

  // Captured command.
  logic                         act;
  logic [6:0]                   widx;
  logic [6:0]                   cidx;
  dir_t                         dir;
  logic signed [COORD_BITS-1:0] wr_x, wr_y;

  // Current point and scan control.
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic [CNT_W-1:0]             scan_idx;
  logic [DRN_W-1:0]             drain_cnt;
  logic                         rd_valid;
  logic [IDX_W-1:0]             rd_idx;

  // Running best.
  logic                         best_found;
  logic [IDX_W-1:0]             best_idx;
  logic [DIST_W-1:0]            best_dist;

  // RAM port signals.
  logic                         ram_we, ram_re;
  logic [IDX_W-1:0]             ram_waddr, ram_raddr;
  logic [2*COORD_BITS-1:0]      ram_rdata;

  // Pipeline outputs.
  logic                         pd_valid, pd_qual;
  logic [IDX_W-1:0]             pd_idx;
  logic [DIST_W-1:0]            pd_dist;

  logic                         accept, cur_out_of_range, wr_in_range, scan_last;
  logic signed [EXT_W-1:0]      x_ext, y_ext;
  logic signed [COORD_BITS-1:0] x_sat, y_sat;
  dir_t                         dir_norm;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Counts above the table size behave as the table size.
  always_comb begin
    if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
      eff_count = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_count = CNT_W'(entry_count);
    end
  end

  assign cur_out_of_range = 32'(cidx) >= 32'(eff_count);
  assign wr_in_range      = 32'(widx) < 32'(MAX_ENTRIES);
  assign scan_last        = (scan_idx == eff_count - CNT_W'(1));

  // Saturate incoming coordinates to the stored width.
  always_comb begin
    x_ext = EXT_W'(coord_x);
    y_ext = EXT_W'(coord_y);
    if (x_ext > CMAX) begin
      x_sat = COORD_BITS'(CMAX);
    end else if (x_ext < CMIN) begin
      x_sat = COORD_BITS'(CMIN);
    end else begin
      x_sat = COORD_BITS'(x_ext);
    end
    if (y_ext > CMAX) begin
      y_sat = COORD_BITS'(CMAX);
    end else if (y_ext < CMIN) begin
      y_sat = COORD_BITS'(CMIN);
    end else begin
      y_sat = COORD_BITS'(y_ext);
    end
    // Codes past right mean any direction.
    dir_norm = (direction > DIR_RIGHT) ? DIR_ANY : direction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = IDX_W'(widx);
    ram_raddr  = IDX_W'(cidx);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_WRITE) ? ST_WRITE : ST_CUR_RD;
        end
      end
      ST_WRITE: begin
        ram_we     = wr_in_range;
        state_next = ST_DONE;
      end
      ST_CUR_RD: begin
        if (cur_out_of_range) begin
          state_next = ST_DONE;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_CUR_WAIT;
        end
      end
      ST_CUR_WAIT: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_idx[IDX_W-1:0];
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRN_W'(SCAN_LATENCY - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      best_idx   <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      if (accept) begin
        best_found <= 1'b0;
        best_idx   <= '0;
      end else if (pd_valid && pd_qual && (!best_found || pd_dist < best_dist)) begin
        // Strict compare keeps the lowest index on equal distances.
        best_found <= 1'b1;
        best_idx   <= pd_idx;
      end
    end

    if (accept) begin
      act  <= action;
      widx <= entry_index;
      cidx <= current_index;
      dir  <= dir_norm;
      wr_x <= x_sat;
      wr_y <= y_sat;
    end
    if (pd_valid && pd_qual && (!best_found || pd_dist < best_dist)) begin
      best_dist <= pd_dist;
    end
    if (state == ST_CUR_WAIT) begin
      cur_x <= ram_rdata[COORD_BITS-1:0];
      cur_y <= ram_rdata[2*COORD_BITS-1:COORD_BITS];
    end
    if (state == ST_SCAN) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end else begin
      scan_idx <= '0;
    end
    if (state == ST_DRAIN) begin
      drain_cnt <= drain_cnt + DRN_W'(1);
    end else begin
      drain_cnt <= '0;
    end
    rd_idx <= scan_idx[IDX_W-1:0];
  end

  assign busy          = (state != ST_IDLE);
  assign done          = (state == ST_DONE);
  // A write leaves the best cleared, so its result reads as not found.
  assign found         = best_found && (act == ACT_SEARCH);
  assign nearest_index = found ? 7'(best_idx) : 7'd0;

  dnps_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({wr_y, wr_x}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dnps_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W),
    .DIST_W     (DIST_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .p_x       (ram_rdata[COORD_BITS-1:0]),
    .p_y       (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .cur_idx   (IDX_W'(cidx)),
    .dir       (dir),
    .out_valid (pd_valid),
    .out_qual  (pd_qual),
    .out_idx   (pd_idx),
    .out_dist  (pd_dist)
  );

endmodule

`default_nettype wire

/* rtl/dnps_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/dnps_dist.sv */
// ----------------------------------------------------------------------------
// Distance pipeline
// Three stages: filter and weighted deltas, squares, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module dnps_dist #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 7,
  parameter int DIST_W     = 2 * (COORD_BITS + 2) + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IDX_W-1:0]             in_idx,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] cur_x,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic [IDX_W-1:0]             cur_idx,
  input  dnps_pkg::dir_t               dir,
  output logic                         out_valid,
  output logic                         out_qual,
  output logic [IDX_W-1:0]             out_idx,
  output logic [DIST_W-1:0]            out_dist
);

  import dnps_pkg::*;

  localparam int DIF_W = COORD_BITS + 1;
  localparam int D_W   = COORD_BITS + 2;
  localparam int SQ_W  = 2 * D_W;

  logic signed [DIF_W-1:0] dx, dy;
  logic signed [D_W-1:0]   dxw, dyw;
  logic                    keep;

  logic                    s1_valid, s1_qual;
  logic [IDX_W-1:0]        s1_idx;
  logic signed [D_W-1:0]   s1_dx, s1_dy;

  logic                    s2_valid, s2_qual;
  logic [IDX_W-1:0]        s2_idx;
  logic signed [SQ_W-1:0]  s2_sqx, s2_sqy;

  always_comb begin
    dx = DIF_W'(p_x) - DIF_W'(cur_x);
    dy = DIF_W'(p_y) - DIF_W'(cur_y);
    // Up/down doubles the x difference, left/right doubles the y difference.
    dxw = (dir == DIR_UP || dir == DIR_DOWN) ? {dx, 1'b0} : {dx[DIF_W-1], dx};
    dyw = (dir == DIR_LEFT || dir == DIR_RIGHT) ? {dy, 1'b0} : {dy[DIF_W-1], dy};
    // Points on the wrong side are dropped; equal coordinates stay.
    unique case (dir)
      DIR_UP:    keep = (dy <= 0);
      DIR_DOWN:  keep = (dy >= 0);
      DIR_LEFT:  keep = (dx <= 0);
      DIR_RIGHT: keep = (dx >= 0);
      default:   keep = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
    s1_qual  <= keep && (in_idx != cur_idx);
    s1_idx   <= in_idx;
    s1_dx    <= dxw;
    s1_dy    <= dyw;
    s2_qual  <= s1_qual;
    s2_idx   <= s1_idx;
    s2_sqx   <= s1_dx * s1_dx;
    s2_sqy   <= s1_dy * s1_dy;
    out_qual <= s2_qual;
    out_idx  <= s2_idx;
    out_dist <= DIST_W'($unsigned(s2_sqx)) + DIST_W'($unsigned(s2_sqy));
  end

endmodule

`default_nettype wire

/* rtl/dnps_checker.sv */
// ----------------------------------------------------------------------------
// Directional nearest-point search: port checker
// Watches the command and result ports of the core over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dnps_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic       found,
  input wire logic [6:0] nearest_index
);

  // An accepted command keeps the core busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a command");

  // A result is shown while the command is still in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a busy period");

  // The strobe lasts one cycle and the core is free right after it.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  // A miss reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (nearest_index == 7'd0))
    else $error("nonzero index with found low");

endmodule

bind directional_nearest_point_search_core dnps_checker u_dnps_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .found         (found),
  .nearest_index (nearest_index)
);

`default_nettype wire

/* sim/directional_nearest_point_search_core_tb.sv */
// ----------------------------------------------------------------------------
// Directional nearest-point search core: testbench
// Writes point tables and runs directional searches over them. Every answer
// is checked against a nearest-point predictor kept alongside the block.
// ----------------------------------------------------------------------------
// Stimulus runs in named tests. The directed tests cover each direction, the
// coordinate extremes and the index limits. Random traffic then runs under
// several entry_count settings, the extremes among them. The sender idles at
// random, and each result beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_nearest_point_search_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dnps_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int MAX_SHOWN   = 10;

  // One answer of the block: the found flag and the winning slot.
  typedef struct packed {
    logic       found;
    logic [6:0] index;
  } nearest_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               action;
  logic [6:0]         entry_index;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  dir_t               direction;
  logic [6:0]         current_index;
  logic               done;
  logic               found;
  logic [6:0]         nearest_index;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;

  directional_nearest_point_search_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .entry_index   (entry_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .direction     (direction),
    .current_index (current_index),
    .done          (done),
    .found         (found),
    .nearest_index (nearest_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the point table and of entry_count, updated at the edge
  // on which each command or register beat is accepted.
  logic signed [15:0] shadow_x [TABLE_DEPTH];
  logic signed [15:0] shadow_y [TABLE_DEPTH];
  bit [TABLE_DEPTH-1:0] slot_written;
  logic [7:0]         shadow_count;

  // Answers still owed by the block, oldest first.
  nearest_t           pending_answers[$];

  int                 error_count;
  int                 idle_pct;

  // 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung block. The slowest legal run is far below this.
  initial begin
    #4_000_000;
    $display("directional_nearest_point_search_core_tb: errors");
    $finish;
  end

  function automatic int active_entries();
    return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
  endfunction

  // Nearest point from slot cur_slot in the given direction. Wrong-side
  // points are dropped, points on the same line are kept, the off-axis
  // difference counts double, and the first slot wins a tie.
  function automatic nearest_t search_nearest(input logic [6:0] cur_slot,
                                              input dir_t dir);
    nearest_t answer;
    dir_t     heading;
    int       limit;
    longint   x_weight;
    longint   y_weight;
    longint   dx;
    longint   dy;
    longint   distance;
    longint   best_dist;
    answer    = '0;
    best_dist = 0;
    limit     = active_entries();
    if (int'(cur_slot) >= limit) return answer;
    // Codes past the last direction behave as no direction at all.
    heading  = (dir > DIR_RIGHT) ? DIR_ANY : dir;
    x_weight = (heading == DIR_UP || heading == DIR_DOWN) ? 2 : 1;
    y_weight = (heading == DIR_LEFT || heading == DIR_RIGHT) ? 2 : 1;
    for (int i = 0; i < limit; i++) begin
      if (i == int'(cur_slot)) continue;
      if (heading == DIR_UP && shadow_y[i] > shadow_y[cur_slot]) continue;
      if (heading == DIR_DOWN && shadow_y[i] < shadow_y[cur_slot]) continue;
      if (heading == DIR_LEFT && shadow_x[i] > shadow_x[cur_slot]) continue;
      if (heading == DIR_RIGHT && shadow_x[i] < shadow_x[cur_slot]) continue;
      dx       = (longint'(shadow_x[i]) - longint'(shadow_x[cur_slot])) * x_weight;
      dy       = (longint'(shadow_y[i]) - longint'(shadow_y[cur_slot])) * y_weight;
      distance = dx * dx + dy * dy;
      if (!answer.found || distance < best_dist) begin
        answer.found = 1'b1;
        answer.index = 7'(i);
        best_dist    = distance;
      end
    end
    return answer;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Coordinates come mostly from a tight cluster, so that ties and points
  // on the same line are common, with full-range values and extremes mixed in.
  function automatic logic signed [15:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 16'(int'($urandom_range(0, 8)) - 4);
    if (roll < 80) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // Send one command beat. The task is entered at a falling edge and leaves
  // at the falling edge after the accept with start still high, so a
  // following beat can go out back to back.
  task automatic send_command(input logic act, input logic [6:0] slot,
                              input logic signed [15:0] px,
                              input logic signed [15:0] py,
                              input dir_t dir, input logic [6:0] cur_slot);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    action        <= act;
    entry_index   <= slot;
    coord_x       <= px;
    coord_y       <= py;
    direction     <= dir;
    current_index <= cur_slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: update the shadow state in command order.
    if (act == ACT_WRITE) begin
      shadow_x[slot]     = px;
      shadow_y[slot]     = py;
      slot_written[slot] = 1'b1;
      pending_answers.push_back('0);
    end else begin
      pending_answers.push_back(search_nearest(cur_slot, dir));
    end
    @(negedge clk);
  endtask

  task automatic write_point(input logic [6:0] slot, input logic signed [15:0] px,
                             input logic signed [15:0] py);
    send_command(ACT_WRITE, slot, px, py, dir_t'($urandom_range(0, 7)),
                 7'($urandom));
  endtask

  task automatic search_from(input logic [6:0] cur_slot, input dir_t dir);
    send_command(ACT_SEARCH, 7'($urandom), pick_coord(), pick_coord(), dir,
                 cur_slot);
  endtask

  // Lower start and wait until the block has answered everything and is
  // idle. Every command answers, so an empty queue with busy low means the
  // block has nothing left in flight.
  task automatic drain_block();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_entry_count(input logic [7:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every done beat must match the oldest prediction.
  always @(posedge clk) begin
    nearest_t wanted;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        note_error($sformatf("unexpected result found=%0b index=%0d",
                             found, nearest_index));
      end else begin
        wanted = pending_answers.pop_front();
        if (found !== wanted.found || nearest_index !== wanted.index) begin
          note_error($sformatf("result mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                               wanted.found, wanted.index, found, nearest_index));
        end
      end
    end
  end

  // A cross of four points around slot 0 at distance 3. Every direction
  // code is tried from the center, including the codes past the last
  // direction. Points level with the center stay candidates for up and down
  // but lose to the point straight ahead because their offset counts double.
  task automatic test_direction_filters();
    set_entry_count(8'd5);
    write_point(7'd0, 16'sd0, 16'sd0);
    write_point(7'd1, 16'sd0, -16'sd3);
    write_point(7'd2, 16'sd0, 16'sd3);
    write_point(7'd3, -16'sd3, 16'sd0);
    write_point(7'd4, 16'sd3, 16'sd0);
    for (int d = 0; d < 8; d++) search_from(7'd0, dir_t'(d));
    // From an arm of the cross, the center and the far arm compete.
    search_from(7'd4, DIR_LEFT);
    search_from(7'd1, DIR_DOWN);
  endtask

  // Points at both corners of the coordinate range, so that the weighted
  // distance reaches its largest values.
  task automatic test_coordinate_extremes();
    write_point(7'd5, 16'sh8000, 16'sh8000);
    write_point(7'd6, 16'sh7fff, 16'sh7fff);
    set_entry_count(8'd7);
    search_from(7'd5, DIR_ANY);
    search_from(7'd6, DIR_UP);
    search_from(7'd5, DIR_RIGHT);
    search_from(7'd6, DIR_LEFT);
    search_from(7'd5, DIR_UP);
  endtask

  // Current slots at or past entry_count must give no match, and slot 6, the last one inside, is searched too.
  task automatic test_index_limits();
    search_from(7'd7, DIR_ANY);
    search_from(7'd127, DIR_DOWN);
    search_from(7'd6, DIR_RIGHT);
  endtask

  // Random traffic under one entry_count setting. All slots a search can
  // read are written first, and a quarter of them are rewritten for variety.
  task automatic test_random_traffic(input logic [7:0] count, input int items);
    int         limit;
    logic [6:0] cur_slot;
    set_entry_count(count);
    limit = active_entries();
    for (int i = 0; i < limit; i++) begin
      if (!slot_written[i] || $urandom_range(0, 3) == 0)
        write_point(7'(i), pick_coord(), pick_coord());
    end
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 25) begin
        write_point(7'($urandom), pick_coord(), pick_coord());
      end else begin
        if (limit == 0) cur_slot = 7'($urandom);
        else if (limit < TABLE_DEPTH && $urandom_range(0, 9) == 0)
          cur_slot = 7'($urandom_range(limit, TABLE_DEPTH - 1));
        else cur_slot = 7'($urandom_range(0, limit - 1));
        search_from(cur_slot, dir_t'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    action        = ACT_WRITE;
    entry_index   = '0;
    coord_x       = '0;
    coord_y       = '0;
    direction     = DIR_ANY;
    current_index = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    shadow_count  = '0;
    slot_written  = '0;
    error_count   = 0;
    idle_pct      = 35;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_direction_filters();
    test_coordinate_extremes();
    test_index_limits();

    // Sender idles often at first, then more often, then never.
    test_random_traffic(8'd2, 180);
    test_random_traffic(8'd128, 180);
    test_random_traffic(8'd0, 180);
    idle_pct = 45;
    test_random_traffic(8'd255, 180);
    test_random_traffic(8'd1, 180);
    test_random_traffic(8'd9, 180);
    idle_pct = 0;
    test_random_traffic(8'd129, 180);
    test_random_traffic(8'd5, 180);
    test_random_traffic(8'd64, 180);

    // Everything owed must arrive, and nothing may follow it.
    drain_block();
    repeat (SCAN_LATENCY + 12) @(posedge clk);
    if (pending_answers.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_answers.size()));
    if (error_count == 0) begin
      $display("directional_nearest_point_search_core_tb: clean");
    end else begin
      $display("directional_nearest_point_search_core_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/dnps_pkg.sv
rtl/dnps_ram.sv
rtl/dnps_dist.sv
rtl/directional_nearest_point_search_core.sv
rtl/dnps_checker.sv
sim/directional_nearest_point_search_core_tb.sv
